FILE: rtl/pwbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbt_pkg - shared definitions for the pulse-width byte transmitter
// Command codes, register indexes, reset values and the types that pass
// between the front end, the request queue and the waveform engine.
// ----------------------------------------------------------------------------
package pwbt_pkg;

	// command field codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MULTIPLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_MULTIPLE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT  = 2'd3;

	// register widths
	localparam int unsigned PT_W   = 12;
	localparam int unsigned LM_W   = 4;
	localparam int unsigned GM_W   = 6;
	localparam int unsigned RC_W   = 8;
	localparam int unsigned CFG_W  = 12;
	localparam int unsigned BYTE_W = 8;

	// reset values
	localparam logic [PT_W-1:0] PT_RST = 12'd350;
	localparam logic [LM_W-1:0] LM_RST = 4'd3;
	localparam logic [GM_W-1:0] GM_RST = 6'd31;
	localparam logic [RC_W-1:0] RC_RST = 8'd10;

	// segment tick counter: holds up to 4095 * 63
	localparam int unsigned SEG_W = 18;

	// default number of data bits per frame
	localparam int unsigned DATA_BITS_DEF = 8;

	// request queue depth
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic              is_tick;
		logic [BYTE_W-1:0] data;
	} item_t;

	typedef struct packed {
		logic [SEG_W-1:0] short_len;
		logic [SEG_W-1:0] long_len;
		logic [SEG_W-1:0] gap_len;
	} lens_t;

endpackage

FILE: rtl/pwbt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbt_cfg - configuration registers
// Holds the four timing registers and keeps registered segment lengths
// (short, long, gap) with zero treated as one.
// ----------------------------------------------------------------------------
module pwbt_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pwbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pwbt_pkg::CFG_W-1:0]     cfg_data,
	output pwbt_pkg::lens_t               lens,
	output logic [pwbt_pkg::RC_W-1:0]      repeat_count
);

	logic [pwbt_pkg::PT_W-1:0] pt_q;
	logic [pwbt_pkg::LM_W-1:0] lm_q;
	logic [pwbt_pkg::GM_W-1:0] gm_q;
	logic [pwbt_pkg::RC_W-1:0] rc_q;
	pwbt_pkg::lens_t           lens_q;

	logic [pwbt_pkg::PT_W-1:0] pt_eff;
	logic [pwbt_pkg::LM_W-1:0] lm_eff;
	logic [pwbt_pkg::GM_W-1:0] gm_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q <= pwbt_pkg::PT_RST;
			lm_q <= pwbt_pkg::LM_RST;
			gm_q <= pwbt_pkg::GM_RST;
			rc_q <= pwbt_pkg::RC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pwbt_pkg::CFG_PULSE_TICKS:   pt_q <= cfg_data[pwbt_pkg::PT_W-1:0];
				pwbt_pkg::CFG_LONG_MULTIPLE: lm_q <= cfg_data[pwbt_pkg::LM_W-1:0];
				pwbt_pkg::CFG_GAP_MULTIPLE:  gm_q <= cfg_data[pwbt_pkg::GM_W-1:0];
				pwbt_pkg::CFG_REPEAT_COUNT:  rc_q <= cfg_data[pwbt_pkg::RC_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one
	assign pt_eff = (pt_q == '0) ? pwbt_pkg::PT_W'(1) : pt_q;
	assign lm_eff = (lm_q == '0) ? pwbt_pkg::LM_W'(1) : lm_q;
	assign gm_eff = (gm_q == '0) ? pwbt_pkg::GM_W'(1) : gm_q;

	always_ff @(posedge clk) begin
		lens_q.short_len <= pwbt_pkg::SEG_W'(pt_eff);
		lens_q.long_len  <= pwbt_pkg::SEG_W'(pt_eff) * pwbt_pkg::SEG_W'(lm_eff);
		lens_q.gap_len   <= pwbt_pkg::SEG_W'(pt_eff) * pwbt_pkg::SEG_W'(gm_eff);
	end

	assign lens         = lens_q;
	assign repeat_count = rc_q;

endmodule

FILE: rtl/pwbt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbt_front - request intake
// Registers each accepted request, tags it as load or tick and hands it
// to the request queue.
// ----------------------------------------------------------------------------
module pwbt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [pwbt_pkg::BYTE_W-1:0] data_byte,
	input  logic                        q_full,
	output logic                        push,
	output pwbt_pkg::item_t             push_item
);

	logic            valid_s1;
	pwbt_pkg::item_t item_s1;

	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.is_tick <= (command == pwbt_pkg::CMD_TICK);
			item_s1.data    <= data_byte;
		end
	end

	assign push_item = item_s1;

endmodule

FILE: rtl/pwbt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbt_queue - request queue
// Short FIFO between intake and the waveform engine so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module pwbt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pwbt_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output pwbt_pkg::item_t head_item
);

	localparam int unsigned DEPTH = pwbt_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pwbt_pkg::item_t   slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: rtl/pwbt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbt_back - waveform engine
// Executes one queued request per cycle against the frame sequencer while the
// output register is empty or being read, and places pin level and status there.
// ----------------------------------------------------------------------------
module pwbt_back #(
	parameter int unsigned DATA_BITS = pwbt_pkg::DATA_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  pwbt_pkg::item_t           head_item,
	output logic                      pop,
	input  pwbt_pkg::lens_t           lens,
	input  logic [pwbt_pkg::RC_W-1:0] repeat_count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      line_level,
	output logic                      busy_res,
	output logic                      done_res
);

	localparam int unsigned BP_W  = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
	localparam int unsigned EXT_W = (DATA_BITS > pwbt_pkg::BYTE_W) ? DATA_BITS
	                                                               : pwbt_pkg::BYTE_W;
	localparam int unsigned SEG_W = pwbt_pkg::SEG_W;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;
	localparam logic [1:0] PH_GAP   = 2'd3;

	logic [pwbt_pkg::BYTE_W-1:0] held_q, held_d;
	logic [DATA_BITS-1:0]        shift_q, shift_d;
	logic [SEG_W-1:0]            cnt_q, cnt_d;
	logic [BP_W-1:0]             bit_q, bit_d;
	logic [1:0]                  phase_q, phase_d;
	logic                        high_q, high_d;
	logic [pwbt_pkg::RC_W-1:0]   rep_q, rep_d;
	logic                        active_q, active_d;

	logic                        out_valid_q;
	logic                        level_q, busy_q, done_q;
	logic                        level_d, busy_d, done_d;

	logic [EXT_W-1:0]            held_ext;
	logic [SEG_W-1:0]            seg_len;
	logic [SEG_W-1:0]            cnt_inc;
	logic                        seg_end;
	logic                        is_long;

	assign pop      = head_valid && (!out_valid_q || out_ready);
	assign held_ext = EXT_W'(held_q);
	assign cnt_inc  = cnt_q + 1'b1;

	always_comb begin
		if (phase_q == PH_START) begin
			is_long = high_q;
		end else begin
			is_long = (shift_q[DATA_BITS-1] == high_q);
		end
		if (phase_q == PH_GAP) begin
			seg_len = lens.gap_len;
		end else if (is_long) begin
			seg_len = lens.long_len;
		end else begin
			seg_len = lens.short_len;
		end
	end

	assign seg_end = (cnt_inc >= seg_len);

	always_comb begin
		held_d   = held_q;
		shift_d  = shift_q;
		cnt_d    = cnt_q;
		bit_d    = bit_q;
		phase_d  = phase_q;
		high_d   = high_q;
		rep_d    = rep_q;
		active_d = active_q;
		level_d  = 1'b0;
		busy_d   = active_q;
		done_d   = 1'b0;

		if (pop) begin
			if (!head_item.is_tick) begin
				// load is dropped while a transmission runs
				if (!active_q) begin
					held_d   = head_item.data;
					cnt_d    = '0;
					bit_d    = '0;
					phase_d  = PH_START;
					high_d   = 1'b1;
					rep_d    = (repeat_count == '0) ? '0 : repeat_count - 1'b1;
					active_d = 1'b1;
				end
				busy_d = 1'b1;
			end else if (active_q) begin
				level_d = (phase_q == PH_GAP) ? 1'b0 : high_q;
				cnt_d   = cnt_inc;
				if (seg_end) begin
					cnt_d = '0;
					case (phase_q)
						PH_START: begin
							if (high_q) begin
								high_d = 1'b0;
							end else begin
								phase_d = PH_DATA;
								high_d  = 1'b1;
								bit_d   = '0;
								shift_d = held_ext[DATA_BITS-1:0];
							end
						end
						PH_DATA: begin
							if (high_q) begin
								high_d = 1'b0;
							end else if (bit_q == BP_W'(DATA_BITS - 1)) begin
								bit_d   = '0;
								phase_d = PH_GAP;
							end else begin
								bit_d   = bit_q + 1'b1;
								shift_d = shift_q << 1;
								high_d  = 1'b1;
							end
						end
						PH_GAP: begin
							if (rep_q == '0) begin
								done_d   = 1'b1;
								active_d = 1'b0;
								phase_d  = PH_IDLE;
								high_d   = 1'b0;
							end else begin
								rep_d   = rep_q - 1'b1;
								phase_d = PH_START;
								high_d  = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			shift_q     <= '0;
			cnt_q       <= '0;
			bit_q       <= '0;
			phase_q     <= PH_IDLE;
			high_q      <= 1'b0;
			rep_q       <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			held_q   <= held_d;
			shift_q  <= shift_d;
			cnt_q    <= cnt_d;
			bit_q    <= bit_d;
			phase_q  <= phase_d;
			high_q   <= high_d;
			rep_q    <= rep_d;
			active_q <= active_d;
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			level_q <= level_d;
			busy_q  <= busy_d;
			done_q  <= done_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_level = level_q;
	assign busy_res   = busy_q;
	assign done_res   = done_q;

`ifndef SYNTHESIS
	// a finished transmission was busy on its last tick
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> busy_q)
		else $error("done reported without busy");

	// sequencer is parked whenever no transmission runs
	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (phase_q == PH_IDLE && !high_q))
		else $error("phase not idle while inactive");

	// the pin is never driven high outside a transmission
	a_level_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && line_level) |-> busy_q)
		else $error("pin high while idle");

	// a done tick leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && done_d) |=> !active_q)
		else $error("still active after done");
`endif

endmodule

FILE: rtl/pulse_width_byte_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_byte_transmitter - pulse-width coded OOK byte transmitter
// Accepts load and tick requests and returns one pin-level result per
// request; the frame repeats a configurable number of times.
// ----------------------------------------------------------------------------
// Each request returns exactly one result. A load request (command 0) latches
// data_byte and starts a transmission unless one is already running, in which
// case it is ignored; its result is level 0, busy 1, done 0. A tick request
// (command 1) advances the waveform one tick and returns the pin level for
// that tick. A frame is a start symbol (long high, short low), DATA_BITS data
// bits MSB first (1 = long high/short low, 0 = short high/long low) and a low
// gap of gap_multiple base pulses; data bits above bit 7 are sent as 0. The
// frame is sent repeat_count times and done_res flags the final gap tick.
// Register indexes: 0 pulse_ticks, 1 long_multiple, 2 gap_multiple,
// 3 repeat_count; a zero value acts as one. Write registers only while no
// request is in flight; a timing change during a transmission applies once
// the registered segment lengths update, repeat_count only at the next load.
// Rate: one request per clock sustained while out_ready keeps the output
// register drained; a request's result passes the intake stage, then the queue,
// then the engine output register. The engine's per-tick compare of the segment
// counter against a registered segment length sets the cycle time.
// ----------------------------------------------------------------------------
module pulse_width_byte_transmitter #(
	parameter int unsigned DATA_BITS = pwbt_pkg::DATA_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pwbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pwbt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [pwbt_pkg::BYTE_W-1:0]    data_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           line_level,
	output logic                           busy_res,
	output logic                           done_res
);

	pwbt_pkg::lens_t           lens;
	logic [pwbt_pkg::RC_W-1:0] repeat_count;
	logic                      q_full;
	logic                      push;
	pwbt_pkg::item_t           push_item;
	logic                      pop;
	logic                      head_valid;
	pwbt_pkg::item_t           head_item;

	// timing registers and precomputed segment lengths
	pwbt_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.lens         (lens),
		.repeat_count (repeat_count)
	);

	// intake: registers and tags each request
	pwbt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decouples intake from the engine
	pwbt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// frame sequencer and output register
	pwbt_back #(
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.lens         (lens),
		.repeat_count (repeat_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.line_level   (line_level),
		.busy_res     (busy_res),
		.done_res     (done_res)
	);

endmodule
